[sv/cfss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfss_pkg - chunked file send sequencer shared definitions
// Phase and command codes, beat layouts and the structs passed between the
// sequencer top level and its chunk-count divider.
// ----------------------------------------------------------------------------
package cfss_pkg;

    // default data bytes per chunk frame (legal range 1..255)
    localparam int CFSS_CHUNK_BYTES_DEF = 128;

    // stream widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // command codes carried on s_axis_tuser
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_NEXT     = 2'd1;
    localparam logic [1:0] CMD_RESEND   = 2'd2;
    localparam logic [1:0] CMD_COMPLETE = 2'd3;

    // send responses
    localparam logic [1:0] SEND_OK   = 2'd0;
    localparam logic [1:0] SEND_BUSY = 2'd1;

    // phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_OPEN  = 3'd1;
    localparam logic [2:0] PH_READ  = 3'd2;
    localparam logic [2:0] PH_XMIT  = 3'd3;
    localparam logic [2:0] PH_CLOSE = 3'd4;

    // one input beat, unpacked
    typedef struct packed {
        logic [1:0]  cmd;
        logic        ble_link;
        logic        uart_link;
        logic        mtu_set;
        logic        notify_enabled;
        logic        count_error;
        logic        files_present;
        logic        open_error;
        logic [31:0] opened_size;
        logic [7:0]  got_bytes;
        logic [1:0]  send_result;
    } item_t;

    // one result beat, unpacked
    typedef struct packed {
        logic [2:0] phase;
        logic       do_delete;
        logic       do_open;
        logic       do_read;
        logic [7:0] read_length;
        logic [7:0] frame_header;
        logic       do_send_serial;
        logic       do_send_radio;
        logic       do_close;
    } result_t;

    // load strobes for the divider pipeline stages
    typedef struct packed {
        logic ld_s2;
        logic ld_s3;
    } cdiv_en_t;

endpackage

[sv/cfss_cdiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfss_cdiv - two-stage divide by the chunk size
// Low eight bits of dividend / CHUNK_BYTES by reciprocal multiply, then a
// remainder check that adds the missing one or two.
// ----------------------------------------------------------------------------
module cfss_cdiv import cfss_pkg::*; #(
    parameter int CHUNK_BYTES = CFSS_CHUNK_BYTES_DEF
) (
    input  logic        aclk,
    input  cdiv_en_t    en,
    input  logic [31:0] dividend,
    output logic [7:0]  quot
);

    // floor((2^32 - 1) / C): estimate undershoots by at most two
    localparam logic [31:0] RECIP  = 32'(64'hFFFF_FFFF / 64'(CHUNK_BYTES));
    localparam logic [9:0]  DIV1X  = 10'(CHUNK_BYTES);
    localparam logic [9:0]  DIV2X  = 10'(2 * CHUNK_BYTES);

    logic [63:0] prod;
    logic [9:0]  qest_lo_reg;
    logic [9:0]  x_lo_reg;
    logic [19:0] back_prod;
    logic [9:0]  rem_lo;
    logic [7:0]  corr;
    logic [7:0]  quot_next;
    logic [7:0]  quot_reg;

    // stage 2: reciprocal product, only low quotient bits kept
    assign prod = 64'(dividend) * 64'(RECIP);

    always_ff @(posedge aclk) begin
        if (en.ld_s2) begin
            qest_lo_reg <= prod[41:32];
            x_lo_reg    <= dividend[9:0];
        end
    end

    // stage 3: remainder is below 3C, so ten bits suffice
    assign back_prod = 20'(qest_lo_reg) * 20'(DIV1X);
    assign rem_lo    = x_lo_reg - back_prod[9:0];

    always_comb begin
        if (rem_lo >= DIV2X) begin
            corr = 8'd2;
        end else if (rem_lo >= DIV1X) begin
            corr = 8'd1;
        end else begin
            corr = 8'd0;
        end
        quot_next = qest_lo_reg[7:0] + corr;
    end

    always_ff @(posedge aclk) begin
        if (en.ld_s3) begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

[sv/chunked_file_send_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_file_send_sequencer_top - chunked file send sequencer
// Idle/open/read/transmit/close sequencer that sends the oldest stored file
// in chunk frames, driven by request and tick beats.
// ----------------------------------------------------------------------------
// Takes one beat per clock when the output is not stalled, and gives one result
// beat per input beat. A beat passes an input register, a two-stage divide by
// the chunk size (the chunk count of a freshly opened file) and the sequencer
// logic into the output register. The output register and the stage registers
// decouple the sides: input beats keep being taken while a result waits,
// until every stage is full. Request beats only latch their flag; tick beats
// run one sequencer step, which may leave the phase unchanged. Rate is set by
// the sequencer update, which is combinational.
module chunked_file_send_sequencer_top import cfss_pkg::*; #(
    parameter int CHUNK_BYTES = CFSS_CHUNK_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input beats
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [0] ble_link, [1] uart_link, [2] mtu_set, [3] notify_enabled,
    // [4] count_error, [5] files_present, [6] open_error,
    // [38:7] opened_size, [46:39] got_bytes, [48:47] send_result, rest zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    // result beats
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [2:0] phase, [3] do_delete, [4] do_open, [5] do_read,
    // [13:6] read_length, [21:14] frame_header, [22] do_send_serial,
    // [23] do_send_radio, [24] do_close, rest zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam logic [7:0]  CHUNK8  = 8'(CHUNK_BYTES);
    localparam logic [31:0] CHUNK32 = 32'(CHUNK_BYTES);

    // pipeline stage registers
    logic    s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    item_t   s1_item_reg, s2_item_reg, s3_item_reg;
    item_t   in_item;
    result_t out_reg, res_next;

    logic out_free, s3_free, s2_free, s1_free, s3_adv;
    cdiv_en_t div_en;
    logic [31:0] div_x;
    logic [7:0]  div_q;

    // sequencer state
    logic [2:0]  phase_reg, phase_next;
    logic        want_next_reg, want_next_next;
    logic        want_resend_reg, want_resend_next;
    logic        want_complete_reg, want_complete_next;
    logic        delete_pending_reg, delete_pending_next;
    logic [31:0] size_held_reg, size_held_next;
    logic [31:0] bytes_done_reg, bytes_done_next;
    logic [7:0]  chunks_left_reg, chunks_left_next;

    logic        links;
    logic        ready_link;
    logic [31:0] remain;

    // unpack input beat
    always_comb begin
        in_item.cmd            = s_axis_tuser[1:0];
        in_item.ble_link       = s_axis_tdata[0];
        in_item.uart_link      = s_axis_tdata[1];
        in_item.mtu_set        = s_axis_tdata[2];
        in_item.notify_enabled = s_axis_tdata[3];
        in_item.count_error    = s_axis_tdata[4];
        in_item.files_present  = s_axis_tdata[5];
        in_item.open_error     = s_axis_tdata[6];
        in_item.opened_size    = s_axis_tdata[38:7];
        in_item.got_bytes      = s_axis_tdata[46:39];
        in_item.send_result    = s_axis_tdata[48:47];
    end

    // stage flow control: a stage loads whenever it is empty or drains
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s3_free       = !s3_valid_reg || out_free;
    assign s2_free       = !s2_valid_reg || s3_free;
    assign s1_free       = !s1_valid_reg || s2_free;
    assign s3_adv        = s3_valid_reg && out_free;
    assign s_axis_tready = s1_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_free) s1_valid_reg <= s_axis_tvalid;
            if (s2_free) s2_valid_reg <= s1_valid_reg;
            if (s3_free) s3_valid_reg <= s2_valid_reg;
            if (out_free) out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_free) s1_item_reg <= in_item;
        if (s2_free) s2_item_reg <= s1_item_reg;
        if (s3_free) s3_item_reg <= s2_item_reg;
        if (s3_adv) out_reg <= res_next;
    end

    // chunks after the first: (size - 1) / chunk, modulo 2^32, low byte
    assign div_x        = s1_item_reg.opened_size - 32'd1;
    assign div_en.ld_s2 = s2_free;
    assign div_en.ld_s3 = s3_free;

    cfss_cdiv #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_cdiv (
        .aclk     (aclk),
        .en       (div_en),
        .dividend (div_x),
        .quot     (div_q)
    );

    assign links      = s3_item_reg.ble_link || s3_item_reg.uart_link;
    assign ready_link = (s3_item_reg.ble_link && s3_item_reg.mtu_set &&
                         s3_item_reg.notify_enabled) || s3_item_reg.uart_link;
    assign remain     = size_held_reg - bytes_done_reg;

    // sequencer step for the beat in stage 3
    always_comb begin
        phase_next          = phase_reg;
        want_next_next      = want_next_reg;
        want_resend_next    = want_resend_reg;
        want_complete_next  = want_complete_reg;
        delete_pending_next = delete_pending_reg;
        size_held_next      = size_held_reg;
        bytes_done_next     = bytes_done_reg;
        chunks_left_next    = chunks_left_reg;
        res_next            = '0;

        case (s3_item_reg.cmd)
            CMD_NEXT:     want_next_next     = 1'b1;
            CMD_RESEND:   want_resend_next   = 1'b1;
            CMD_COMPLETE: want_complete_next = 1'b1;
            default: begin
                case (phase_reg)
                    PH_IDLE: begin
                        if (!links) begin
                            want_next_next     = 1'b0;
                            want_resend_next   = 1'b0;
                            want_complete_next = 1'b0;
                        end else if (ready_link) begin
                            if (want_next_reg) begin
                                want_next_next      = 1'b0;
                                res_next.do_delete  = delete_pending_reg;
                                delete_pending_next = 1'b0;
                                phase_next          = PH_OPEN;
                            end else if (want_complete_reg) begin
                                want_complete_next  = 1'b0;
                                res_next.do_delete  = delete_pending_reg;
                                delete_pending_next = 1'b0;
                            end else if (want_resend_reg) begin
                                want_resend_next    = 1'b0;
                                delete_pending_next = 1'b0;
                                phase_next          = PH_OPEN;
                            end
                        end
                    end
                    PH_OPEN: begin
                        if (!links) begin
                            want_next_next     = 1'b0;
                            want_resend_next   = 1'b0;
                            want_complete_next = 1'b0;
                            phase_next         = PH_IDLE;
                        end else if (!s3_item_reg.count_error &&
                                     s3_item_reg.files_present) begin
                            res_next.do_open = 1'b1;
                            bytes_done_next  = '0;
                            if (!s3_item_reg.open_error) begin
                                size_held_next   = s3_item_reg.opened_size;
                                chunks_left_next = div_q;
                                phase_next       = PH_READ;
                            end
                        end
                    end
                    PH_READ: begin
                        if (!links) begin
                            res_next.do_close  = 1'b1;
                            want_next_next     = 1'b0;
                            want_resend_next   = 1'b0;
                            want_complete_next = 1'b0;
                            phase_next         = PH_IDLE;
                        end else begin
                            res_next.do_read      = 1'b1;
                            res_next.frame_header = chunks_left_reg;
                            res_next.read_length  = (remain >= CHUNK32) ? CHUNK8
                                                                        : remain[7:0];
                            bytes_done_next = bytes_done_reg +
                                              32'(s3_item_reg.got_bytes);
                            phase_next      = PH_XMIT;
                        end
                    end
                    PH_XMIT: begin
                        if (!links) begin
                            res_next.do_close  = 1'b1;
                            want_next_next     = 1'b0;
                            want_resend_next   = 1'b0;
                            want_complete_next = 1'b0;
                            phase_next         = PH_IDLE;
                        end else begin
                            res_next.do_send_serial = s3_item_reg.uart_link;
                            res_next.do_send_radio  = !s3_item_reg.uart_link;
                            res_next.frame_header   = chunks_left_reg;
                            if (s3_item_reg.send_result == SEND_OK) begin
                                if (chunks_left_reg != 8'd0) begin
                                    chunks_left_next = chunks_left_reg - 8'd1;
                                    phase_next       = PH_READ;
                                end else begin
                                    phase_next = PH_CLOSE;
                                end
                            end else if (s3_item_reg.send_result != SEND_BUSY) begin
                                // failed send: give up on this file
                                res_next.do_close = 1'b1;
                                phase_next        = PH_IDLE;
                            end
                        end
                    end
                    PH_CLOSE: begin
                        res_next.do_close   = 1'b1;
                        delete_pending_next = 1'b1;
                        phase_next          = PH_IDLE;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        endcase
        res_next.phase = phase_next;
    end

    // state commits when the beat moves into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            want_next_reg      <= 1'b0;
            want_resend_reg    <= 1'b0;
            want_complete_reg  <= 1'b0;
            delete_pending_reg <= 1'b0;
            size_held_reg      <= '0;
            bytes_done_reg     <= '0;
            chunks_left_reg    <= '0;
        end else if (s3_adv) begin
            phase_reg          <= phase_next;
            want_next_reg      <= want_next_next;
            want_resend_reg    <= want_resend_next;
            want_complete_reg  <= want_complete_next;
            delete_pending_reg <= delete_pending_next;
            size_held_reg      <= size_held_next;
            bytes_done_reg     <= bytes_done_next;
            chunks_left_reg    <= chunks_left_next;
        end
    end

    // pack result beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            out_reg.do_close,
                            out_reg.do_send_radio,
                            out_reg.do_send_serial,
                            out_reg.frame_header,
                            out_reg.read_length,
                            out_reg.do_read,
                            out_reg.do_open,
                            out_reg.do_delete,
                            out_reg.phase};

endmodule
